/* sv/csvfp_pkg.sv */
// ----------------------------------------------------------------------------
// csvfp_pkg
// Types and constants shared by the CSV field parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfp_pkg;

  localparam int ByteW       = 8;
  localparam int FieldIdxW   = 8;
  localparam int CfgIndexW   = 2;
  localparam int CfgDataW    = 8;

  // Largest field index before the counter saturates, clipped to the field width
  localparam int MaxFieldIndex = 255;
  localparam int IdxMax        = (1 << FieldIdxW) - 1;
  localparam logic [FieldIdxW-1:0] IndexLimit =
      (MaxFieldIndex > IdxMax) ? FieldIdxW'(IdxMax) : FieldIdxW'(MaxFieldIndex);

  localparam logic [ByteW-1:0] SeparatorReset = 8'd44;  // comma
  localparam logic [ByteW-1:0] QuoteReset     = 8'd34;  // double quote

  localparam logic [CfgIndexW-1:0] RegSeparator = 2'd0;
  localparam logic [CfgIndexW-1:0] RegQuote     = 2'd1;

  typedef enum logic [2:0] {
    PhStart     = 3'd0,
    PhPlain     = 3'd1,
    PhQuoted    = 3'd2,
    PhQuoteSeen = 3'd3,
    PhAfter     = 3'd4
  } csvfp_phase_e;

  typedef enum logic [1:0] {
    KindData     = 2'd0,
    KindFieldEnd = 2'd1,
    KindLineEnd  = 2'd2,
    KindEmpty    = 2'd3
  } csvfp_kind_e;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] in_byte;
  } csvfp_item_t;

  typedef struct packed {
    logic                 valid;
    csvfp_kind_e          kind;
    logic [ByteW-1:0]     data;
    logic [FieldIdxW-1:0] field_idx;
  } csvfp_result_t;

endpackage

`default_nettype wire

/* sv/csvfp_if.sv */
// ----------------------------------------------------------------------------
// csvfp channel interfaces
// Valid/ready channels for line items, parse results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvfp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [csvfp_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface csvfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    result_kind;
  logic [csvfp_pkg::ByteW-1:0]     out_byte;
  logic [csvfp_pkg::FieldIdxW-1:0] field_index;

  modport source (output valid, output result_kind, output out_byte, output field_index,
                  input ready);
  modport sink   (input valid, input result_kind, input out_byte, input field_index,
                  output ready);
endinterface

interface csvfp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [csvfp_pkg::CfgIndexW-1:0] index;
  logic [csvfp_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/csvfp_parse.sv */
// ----------------------------------------------------------------------------
// csvfp_parse
// Per-line parse state and the one-step field/quote decision for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfp_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_en_i,
  input  wire csvfp_pkg::csvfp_item_t      item_i,
  input  wire logic [csvfp_pkg::ByteW-1:0] separator_i,
  input  wire logic [csvfp_pkg::ByteW-1:0] quote_i,
  output csvfp_pkg::csvfp_result_t         result_o
);

  csvfp_pkg::csvfp_phase_e phase_q, phase_d;
  logic                              line_has_chars_q, line_has_chars_d;
  logic [csvfp_pkg::FieldIdxW-1:0]   field_cnt_q, field_cnt_d;
  logic                              is_quote, is_sep;

  assign is_quote = (item_i.in_byte == quote_i);
  assign is_sep   = (item_i.in_byte == separator_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= csvfp_pkg::PhStart;
      line_has_chars_q <= 1'b0;
      field_cnt_q      <= '0;
    end else if (step_en_i) begin
      phase_q          <= phase_d;
      line_has_chars_q <= line_has_chars_d;
      field_cnt_q      <= field_cnt_d;
    end
  end

  always_comb begin
    logic field_end;
    logic emit_data;
    field_end        = 1'b0;
    emit_data        = 1'b0;
    phase_d          = phase_q;
    line_has_chars_d = line_has_chars_q;
    field_cnt_d      = field_cnt_q;
    result_o.valid     = 1'b0;
    result_o.kind      = csvfp_pkg::KindData;
    result_o.data      = '0;
    result_o.field_idx = field_cnt_q;

    if (item_i.req_type) begin
      result_o.valid = 1'b1;
      if (!line_has_chars_q) begin
        result_o.kind      = csvfp_pkg::KindEmpty;
        result_o.field_idx = '0;
      end else begin
        result_o.kind = csvfp_pkg::KindLineEnd;
      end
      phase_d          = csvfp_pkg::PhStart;
      line_has_chars_d = 1'b0;
      field_cnt_d      = '0;
    end else begin
      line_has_chars_d = 1'b1;
      unique case (phase_q)
        csvfp_pkg::PhQuoted: begin
          if (is_quote) phase_d = csvfp_pkg::PhQuoteSeen;
          else          emit_data = 1'b1;
        end
        csvfp_pkg::PhQuoteSeen: begin
          // held quote: doubled quote, closing quote + separator, or closing quote
          if (is_quote) begin
            phase_d   = csvfp_pkg::PhQuoted;
            emit_data = 1'b1;
          end else if (is_sep) begin
            field_end = 1'b1;
          end else begin
            phase_d   = csvfp_pkg::PhAfter;
            emit_data = 1'b1;
          end
        end
        csvfp_pkg::PhPlain, csvfp_pkg::PhAfter: begin
          if (is_sep) field_end = 1'b1;
          else        emit_data = 1'b1;
        end
        default: begin
          // quote meaning wins over separator when both bytes match
          if (is_quote) begin
            phase_d = csvfp_pkg::PhQuoted;
          end else if (is_sep) begin
            field_end = 1'b1;
          end else begin
            phase_d   = csvfp_pkg::PhPlain;
            emit_data = 1'b1;
          end
        end
      endcase

      if (emit_data) begin
        result_o.valid = 1'b1;
        result_o.data  = item_i.in_byte;
      end
      if (field_end) begin
        result_o.valid = 1'b1;
        result_o.kind  = csvfp_pkg::KindFieldEnd;
        phase_d        = csvfp_pkg::PhStart;
        if (field_cnt_q < csvfp_pkg::IndexLimit) field_cnt_d = field_cnt_q + 1'b1;
      end
    end
  end

  // ---- assertions ----
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_cnt_q <= csvfp_pkg::IndexLimit)
    else $error("field counter above limit");

  a_line_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && item_i.req_type |=> !line_has_chars_q && field_cnt_q == '0 &&
      phase_q == csvfp_pkg::PhStart)
    else $error("line end did not clear parse state");

  a_cnt_moves_on_field_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_cnt_q != $past(field_cnt_q) |->
      $past(step_en_i) && ($past(item_i.req_type) ||
      $past(result_o.kind) == csvfp_pkg::KindFieldEnd))
    else $error("field counter changed without a field or line end");

endmodule

`default_nettype wire

/* sv/csv_field_parser.sv */
// ----------------------------------------------------------------------------
// csv_field_parser
// CSV line splitter: one character or end-of-line per transaction in,
// at most one data/field-end/line-end/empty-line result per transaction out.
// ----------------------------------------------------------------------------
// The parser takes one transaction per clock while its input ready is high. An
// accepted item is held in an input register, is decided there by the
// quote/separator logic and, once the parse step is enabled, lands in the
// output register, from which its result is offered.
// Throughput is one item per cycle unless stalled, set by the update of the
// phase and field counter; input ready drops only while the input register
// holds an item with a result and the output register is full and not being
// taken. Register writes (separator, quote) are taken at any time
// and belong between lines while the parser is idle.
`default_nettype none

module csv_field_parser (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  csvfp_in_if.sink    in_if,
  csvfp_out_if.source out_if,
  csvfp_cfg_if.sink   cfg_if
);

  logic [csvfp_pkg::ByteW-1:0] separator_q, quote_q;
  logic                        stage_valid_q;
  csvfp_pkg::csvfp_item_t      stage_q;
  logic                        out_valid_q;
  csvfp_pkg::csvfp_result_t    out_q;
  csvfp_pkg::csvfp_result_t    result;
  logic                        out_free, step_en, in_xact;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      separator_q <= csvfp_pkg::SeparatorReset;
      quote_q     <= csvfp_pkg::QuoteReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        csvfp_pkg::RegSeparator: separator_q <= cfg_if.data;
        csvfp_pkg::RegQuote:     quote_q     <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign out_free     = !out_valid_q || out_if.ready;
  assign step_en      = stage_valid_q && (out_free || !result.valid);
  assign in_if.ready  = !stage_valid_q || step_en;
  assign in_xact      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      stage_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      stage_q.req_type <= in_if.req_type;
      stage_q.in_byte  <= in_if.in_byte;
    end
  end

  csvfp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .item_i      (stage_q),
    .separator_i (separator_q),
    .quote_i     (quote_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_en && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && result.valid) out_q <= result;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.result_kind = out_q.kind;
  assign out_if.out_byte    = out_q.data;
  assign out_if.field_index = out_q.field_idx;

  // ---- assertions ----
  a_ready_only_blocked_by_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> stage_valid_q && out_valid_q && !out_if.ready)
    else $error("input stalled without a full pipeline");

  a_nondata_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != csvfp_pkg::KindData |-> out_q.data == '0)
    else $error("non-data result carries a byte");

  a_empty_line_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == csvfp_pkg::KindEmpty |-> out_q.field_idx == '0)
    else $error("empty line result with nonzero field index");

endmodule

`default_nettype wire
